// File: rtl/wsd_pkg.sv
// shared widths and codes for the work-stealing deque
package wsd_pkg;

  localparam int WORD_W = 64;
  localparam int CMD_W  = 2;
  localparam int STAT_W = 2;
  localparam int FILL_W = 5;

  localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_STEAL = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

endpackage

// File: rtl/work_stealing_deque_top.sv
// work-stealing deque: ring buffer with push/pop at tail and steal at head
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------------
//  command  | start, busy          | in_cmd, in_push_value
//  result   | out_valid (1 cycle)  | out_status, out_taken_value, out_fill_count
//
// one command per cycle; busy stays low, so a command is taken at every edge with start high
// the result is registered and shows in the cycle after the command edge, held for that single cycle
// pointers and the slot read/write all settle at the command edge; the slot read is registered
// reset clears head, tail and the result strobe; slot contents are left as they are
// the receiver cannot stall, so nothing is ever held back
module work_stealing_deque_top #(
  parameter int DEPTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [wsd_pkg::CMD_W-1:0]     in_cmd,
  input  logic [wsd_pkg::WORD_W-1:0]    in_push_value,
  output logic                          out_valid,
  output logic [wsd_pkg::STAT_W-1:0]    out_status,
  output logic [wsd_pkg::WORD_W-1:0]    out_taken_value,
  output logic [wsd_pkg::FILL_W-1:0]    out_fill_count
);
  import wsd_pkg::*;

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = (AW > FILL_W) ? AW : FILL_W;
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic [WORD_W-1:0] mem [DEPTH];

  logic [AW-1:0]     head_r, head_nxt;
  logic [AW-1:0]     tail_r, tail_nxt;
  logic              valid_r;
  logic [STAT_W-1:0] status_r, status_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic              take_r, take_nxt;
  logic [WORD_W-1:0] rd_r;

  logic              accept;
  logic [AW-1:0]     count, count_nxt;
  logic [AW-1:0]     tail_inc, tail_dec, head_inc;
  logic              wr_en, rd_en;
  logic [AW-1:0]     rd_addr;
  logic [CNTW-1:0]   count_ext;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign tail_inc = (tail_r == LAST) ? '0 : tail_r + AW'(1);
  assign tail_dec = (tail_r == '0) ? LAST : tail_r - AW'(1);
  assign head_inc = (head_r == LAST) ? '0 : head_r + AW'(1);

  // occupancy modulo depth, depth need not be a power of two
  assign count = (tail_r >= head_r) ? tail_r - head_r : tail_r + LAST + AW'(1) - head_r;

  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    status_nxt = ST_OK;
    take_nxt   = 1'b0;
    count_nxt  = count;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = head_r;
    unique case (in_cmd)
      CMD_PUSH: begin
        if (count == LAST) begin
          status_nxt = ST_FULL;
        end else begin
          wr_en     = 1'b1;
          tail_nxt  = tail_inc;
          count_nxt = count + AW'(1);
        end
      end
      CMD_POP: begin
        if (count == '0) begin
          status_nxt = ST_EMPTY;
        end else begin
          rd_en     = 1'b1;
          take_nxt  = 1'b1;
          rd_addr   = tail_dec;
          tail_nxt  = tail_dec;
          count_nxt = count - AW'(1);
        end
      end
      CMD_STEAL: begin
        if (count == '0) begin
          status_nxt = ST_EMPTY;
        end else begin
          rd_en     = 1'b1;
          take_nxt  = 1'b1;
          rd_addr   = head_r;
          head_nxt  = head_inc;
          count_nxt = count - AW'(1);
        end
      end
      default: begin
        // unused code: report current fill, touch nothing
      end
    endcase
  end

  assign count_ext = CNTW'(count_nxt);
  assign fill_nxt  = count_ext[FILL_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      valid_r <= accept;
      if (accept) begin
        head_r <= head_nxt;
        tail_r <= tail_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      fill_r   <= fill_nxt;
      take_r   <= take_nxt;
    end
  end

  // slot store: per cycle, either one write (push) or one registered read (pop, steal)
  always_ff @(posedge clk) begin
    if (accept && wr_en) begin
      mem[tail_r] <= in_push_value;
    end
    if (accept && rd_en) begin
      rd_r <= mem[rd_addr];
    end
  end

  assign out_valid       = valid_r;
  assign out_status      = status_r;
  assign out_fill_count  = fill_r;
  assign out_taken_value = take_r ? rd_r : '0;

endmodule

// File: rtl/wsd_checker.sv
// port-level checks for the work-stealing deque, bound to the top level
module wsd_checker #(
  parameter int DEPTH = 32
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic [wsd_pkg::CMD_W-1:0]     in_cmd,
  input logic                          out_valid,
  input logic [wsd_pkg::STAT_W-1:0]    out_status,
  input logic [wsd_pkg::WORD_W-1:0]    out_taken_value,
  input logic [wsd_pkg::FILL_W-1:0]    out_fill_count
);
  import wsd_pkg::*;

  // every accepted command gives exactly one result beat on the next cycle
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> out_valid)
    else $error("accepted command gave no result beat");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |=> !out_valid)
    else $error("result beat without an accepted command");

  // failed commands return no word
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_taken_value == '0))
    else $error("failed command returned a word");

  // a push never hands a word back
  a_push_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_cmd == CMD_PUSH) |=> (out_taken_value == '0))
    else $error("push returned a word");

  // empty and full statuses must agree with the reported fill
  a_fill_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_status == ST_EMPTY && out_fill_count == '0) ||
                   (out_status == ST_FULL && out_fill_count == FILL_W'(DEPTH - 1)) ||
                   (out_status == ST_OK)))
    else $error("status and fill count disagree");

endmodule

bind work_stealing_deque_top wsd_checker #(.DEPTH(DEPTH)) u_wsd_checker (.*);
